FILE: hw/rtl/intu_pkg.sv
// Shared types, microcode table and entry points for the integer number theory unit.
package intu_pkg;

    localparam int PC_W = 6;

    localparam logic [2:0] FN_GCD   = 3'd0;
    localparam logic [2:0] FN_LCM   = 3'd1;
    localparam logic [2:0] FN_FACT  = 3'd2;
    localparam logic [2:0] FN_POW   = 3'd3;
    localparam logic [2:0] FN_ARR   = 3'd4;
    localparam logic [2:0] FN_COMB  = 3'd5;
    localparam logic [2:0] FN_BINOM = 3'd6;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_DIV_LD_AB,   // divide working a by working b
        OP_DIV_LD_XG,   // divide original a by the gcd
        OP_DIV,         // one restoring division bit, repeats WIDTH times
        OP_GCD_UPD,
        OP_ACC_A,
        OP_ACC_Q,
        OP_ACC0,
        OP_ACC1,
        OP_MUL_LD,
        OP_MUL,         // one shift-add bit, repeats WIDTH times
        OP_MUL_WB,
        OP_BASE_A,
        OP_BASE_SUM,
        OP_I_ONE,
        OP_I_NK,
        OP_I_INC,
        OP_J_ONE,
        OP_RD_J,
        OP_ROW_ADD,
        OP_RD_K,
        OP_ACC_MEM,
        OP_BAD,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_B_ZERO,
        C_AB_ZERO,
        C_A_OR_B_ZERO,
        C_K_GT_N,
        C_I_GT_N,
        C_J_NE_I
    } cond_t;

    typedef enum logic [1:0] {
        SRC_I,
        SRC_Y,
        SRC_BASE
    } src_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        src_t            src;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] L_GCD      = 6'd0;
    localparam logic [PC_W-1:0] L_GCD_END  = 6'd4;
    localparam logic [PC_W-1:0] L_LCM      = 6'd5;
    localparam logic [PC_W-1:0] L_LCM_LOOP = 6'd7;
    localparam logic [PC_W-1:0] L_LCM_DIV  = 6'd11;
    localparam logic [PC_W-1:0] L_FACT     = 6'd17;
    localparam logic [PC_W-1:0] L_ARR      = 6'd19;
    localparam logic [PC_W-1:0] L_POW      = 6'd22;
    localparam logic [PC_W-1:0] L_POW_INIT = 6'd23;
    localparam logic [PC_W-1:0] L_BINOM    = 6'd25;
    localparam logic [PC_W-1:0] L_LOOPI    = 6'd26;
    localparam logic [PC_W-1:0] L_LOOPB    = 6'd31;
    localparam logic [PC_W-1:0] L_COMB     = 6'd36;
    localparam logic [PC_W-1:0] L_ROW      = 6'd38;
    localparam logic [PC_W-1:0] L_RD_J     = 6'd40;
    localparam logic [PC_W-1:0] L_RESULT   = 6'd43;
    localparam logic [PC_W-1:0] L_BAD      = 6'd45;
    localparam logic [PC_W-1:0] L_ZERO     = 6'd46;
    localparam logic [PC_W-1:0] L_DONE     = 6'd47;

    function automatic uword_t uw(input op_t o, input cond_t c, input src_t s,
                                  input logic [PC_W-1:0] t);
        uword_t w;
        w.op     = o;
        w.cond   = c;
        w.src    = s;
        w.target = t;
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry(input logic [2:0] fn);
        logic [PC_W-1:0] r;
        unique case (fn)
            FN_GCD:   r = L_GCD;
            FN_LCM:   r = L_LCM;
            FN_FACT:  r = L_FACT;
            FN_POW:   r = L_POW;
            FN_ARR:   r = L_ARR;
            FN_COMB:  r = L_COMB;
            FN_BINOM: r = L_BINOM;
            default:  r = L_BAD;
        endcase
        return r;
    endfunction

    function automatic uword_t rom(input logic [PC_W-1:0] pc);
        uword_t r;
        unique case (pc)
            // gcd
            6'd0:  r = uw(OP_NOP,       C_B_ZERO,      SRC_I,    L_GCD_END);
            6'd1:  r = uw(OP_DIV_LD_AB, C_NONE,        SRC_I,    L_GCD);
            6'd2:  r = uw(OP_DIV,       C_NONE,        SRC_I,    L_GCD);
            6'd3:  r = uw(OP_GCD_UPD,   C_ALWAYS,      SRC_I,    L_GCD);
            6'd4:  r = uw(OP_ACC_A,     C_ALWAYS,      SRC_I,    L_DONE);
            // lcm
            6'd5:  r = uw(OP_NOP,       C_AB_ZERO,     SRC_I,    L_BAD);
            6'd6:  r = uw(OP_NOP,       C_A_OR_B_ZERO, SRC_I,    L_ZERO);
            6'd7:  r = uw(OP_NOP,       C_B_ZERO,      SRC_I,    L_LCM_DIV);
            6'd8:  r = uw(OP_DIV_LD_AB, C_NONE,        SRC_I,    L_GCD);
            6'd9:  r = uw(OP_DIV,       C_NONE,        SRC_I,    L_GCD);
            6'd10: r = uw(OP_GCD_UPD,   C_ALWAYS,      SRC_I,    L_LCM_LOOP);
            6'd11: r = uw(OP_DIV_LD_XG, C_NONE,        SRC_I,    L_GCD);
            6'd12: r = uw(OP_DIV,       C_NONE,        SRC_I,    L_GCD);
            6'd13: r = uw(OP_ACC_Q,     C_NONE,        SRC_I,    L_GCD);
            6'd14: r = uw(OP_MUL_LD,    C_NONE,        SRC_Y,    L_GCD);
            6'd15: r = uw(OP_MUL,       C_NONE,        SRC_Y,    L_GCD);
            6'd16: r = uw(OP_MUL_WB,    C_ALWAYS,      SRC_Y,    L_DONE);
            // factorial
            6'd17: r = uw(OP_ACC1,      C_NONE,        SRC_I,    L_GCD);
            6'd18: r = uw(OP_I_ONE,     C_ALWAYS,      SRC_I,    L_LOOPI);
            // arrangements
            6'd19: r = uw(OP_NOP,       C_K_GT_N,      SRC_I,    L_BAD);
            6'd20: r = uw(OP_ACC1,      C_NONE,        SRC_I,    L_GCD);
            6'd21: r = uw(OP_I_NK,      C_ALWAYS,      SRC_I,    L_LOOPI);
            // power and binomial sum
            6'd22: r = uw(OP_BASE_A,    C_NONE,        SRC_I,    L_GCD);
            6'd23: r = uw(OP_ACC1,      C_NONE,        SRC_I,    L_GCD);
            6'd24: r = uw(OP_I_ONE,     C_ALWAYS,      SRC_I,    L_LOOPB);
            6'd25: r = uw(OP_BASE_SUM,  C_ALWAYS,      SRC_I,    L_POW_INIT);
            // product over the index
            6'd26: r = uw(OP_NOP,       C_I_GT_N,      SRC_I,    L_DONE);
            6'd27: r = uw(OP_MUL_LD,    C_NONE,        SRC_I,    L_GCD);
            6'd28: r = uw(OP_MUL,       C_NONE,        SRC_I,    L_GCD);
            6'd29: r = uw(OP_MUL_WB,    C_NONE,        SRC_I,    L_GCD);
            6'd30: r = uw(OP_I_INC,     C_ALWAYS,      SRC_I,    L_LOOPI);
            // repeated product of the base
            6'd31: r = uw(OP_NOP,       C_I_GT_N,      SRC_BASE, L_DONE);
            6'd32: r = uw(OP_MUL_LD,    C_NONE,        SRC_BASE, L_GCD);
            6'd33: r = uw(OP_MUL,       C_NONE,        SRC_BASE, L_GCD);
            6'd34: r = uw(OP_MUL_WB,    C_NONE,        SRC_BASE, L_GCD);
            6'd35: r = uw(OP_I_INC,     C_ALWAYS,      SRC_BASE, L_LOOPB);
            // combinations by Pascal rows
            6'd36: r = uw(OP_NOP,       C_K_GT_N,      SRC_I,    L_BAD);
            6'd37: r = uw(OP_I_ONE,     C_NONE,        SRC_I,    L_GCD);
            6'd38: r = uw(OP_NOP,       C_I_GT_N,      SRC_I,    L_RESULT);
            6'd39: r = uw(OP_J_ONE,     C_NONE,        SRC_I,    L_GCD);
            6'd40: r = uw(OP_RD_J,      C_NONE,        SRC_I,    L_GCD);
            6'd41: r = uw(OP_ROW_ADD,   C_J_NE_I,      SRC_I,    L_RD_J);
            6'd42: r = uw(OP_I_INC,     C_ALWAYS,      SRC_I,    L_ROW);
            6'd43: r = uw(OP_RD_K,      C_NONE,        SRC_I,    L_GCD);
            6'd44: r = uw(OP_ACC_MEM,   C_ALWAYS,      SRC_I,    L_DONE);
            // common exits
            6'd45: r = uw(OP_BAD,       C_ALWAYS,      SRC_I,    L_DONE);
            6'd46: r = uw(OP_ACC0,      C_ALWAYS,      SRC_I,    L_DONE);
            6'd47: r = uw(OP_DONE,      C_NONE,        SRC_I,    L_DONE);
            default: r = uw(OP_BAD,     C_ALWAYS,      SRC_I,    L_DONE);
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/integer_number_theory_unit.sv
// Top level: microcoded gcd, lcm, factorial, power, nPk, nCk and binomial sum unit.
// Each Euclid remainder and each product step runs through the shared shift/subtract unit;
// gcd needs up to about 1.5*WIDTH remainders, factorial, power and binomial sum n products, nPk k;
// nCk builds the Pascal row table row by row, one entry at a time.
// One request at a time; a new word is taken once the previous result is registered.
// Reset clears the sequencer and output valid; the row table is not cleared.
module integer_number_theory_unit #(
    parameter int WIDTH     = 32,
    parameter int COUNT_MAX = 63
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // func, op_a, op_b, count_n, count_k
    input  logic [((2*WIDTH+15+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // value, overflow, bad_args
    output logic [((WIDTH+2+7)/8)*8-1:0]           m_tdata
);

    localparam int OUT_W = ((WIDTH + 2 + 7) / 8) * 8;
    localparam int CW    = $clog2(COUNT_MAX + 1);
    localparam int BW    = $clog2(WIDTH);
    localparam int DEPTH = COUNT_MAX + 1;

    // sequencer
    logic                        busy_reg, busy_next;
    logic [intu_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [BW-1:0]               bitc_reg, bitc_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    intu_pkg::uword_t            uword;
    logic                        take;
    logic                        out_free;
    logic                        accept;

    // datapath
    logic [WIDTH-1:0]  a_reg, b_reg, x_reg, y_reg;
    logic [WIDTH-1:0]  acc_reg, md_reg, sh_reg, hi_reg, base_reg, prev_reg;
    logic              big_reg, base_big_reg, prev_big_reg, zf_reg, bf_reg, bad_reg;
    logic [CW-1:0]     n_reg, k_reg;
    logic [CW:0]       i_reg, j_reg;
    logic [WIDTH:0]    mem [DEPTH];
    logic [WIDTH:0]    rd_reg;
    logic [CW-1:0]     rd_addr;

    logic [WIDTH-1:0]  value_reg;
    logic              ovf_reg, badout_reg;

    logic [5:0]        cnt_n_in, cnt_k_in;
    logic [WIDTH-1:0]  opnd;
    logic              opnd_big;
    logic [WIDTH:0]    mul_sum;
    logic [WIDTH:0]    div_rem;
    logic              div_ge;
    logic [WIDTH-1:0]  cur_lo;
    logic              cur_big;
    logic [WIDTH:0]    row_sum;
    logic [WIDTH:0]    ab_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({badout_reg, ovf_reg, value_reg});
    assign out_free = !m_tvalid_reg || m_tready;
    assign uword    = intu_pkg::rom(pc_reg);

    assign cnt_n_in = s_tdata[2*WIDTH+3 +: 6];
    assign cnt_k_in = s_tdata[2*WIDTH+9 +: 6];

    always_comb
    begin
        unique case (uword.cond)
            intu_pkg::C_NONE:        take = 1'b0;
            intu_pkg::C_ALWAYS:      take = 1'b1;
            intu_pkg::C_B_ZERO:      take = (b_reg == '0);
            intu_pkg::C_AB_ZERO:     take = (x_reg == '0) && (y_reg == '0);
            intu_pkg::C_A_OR_B_ZERO: take = (x_reg == '0) || (y_reg == '0);
            intu_pkg::C_K_GT_N:      take = (k_reg > n_reg);
            intu_pkg::C_I_GT_N:      take = (i_reg > {1'b0, n_reg});
            intu_pkg::C_J_NE_I:      take = (j_reg != i_reg);
            default:                 take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        bitc_next     = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (!busy_reg)
        begin
            if (accept)
            begin
                busy_next = 1'b1;
                pc_next   = intu_pkg::entry(s_tdata[2:0]);
            end
        end
        else if ((uword.op == intu_pkg::OP_MUL || uword.op == intu_pkg::OP_DIV) &&
                 bitc_reg != BW'(WIDTH - 1))
        begin
            bitc_next = bitc_reg + 1'b1;
        end
        else if (uword.op == intu_pkg::OP_DONE)
        begin
            if (out_free)
            begin
                busy_next     = 1'b0;
                m_tvalid_next = 1'b1;
            end
        end
        else
        begin
            pc_next = take ? uword.target : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pc_reg       <= '0;
            bitc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pc_reg       <= pc_next;
            bitc_reg     <= bitc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // operand of a multiplication
    always_comb
    begin
        unique case (uword.src)
            intu_pkg::SRC_Y:
            begin
                opnd     = y_reg;
                opnd_big = 1'b0;
            end
            intu_pkg::SRC_BASE:
            begin
                opnd     = base_reg;
                opnd_big = base_big_reg;
            end
            default:
            begin
                opnd     = WIDTH'(i_reg);
                opnd_big = 1'b0;
            end
        endcase
    end

    assign mul_sum = {1'b0, hi_reg} + (sh_reg[0] ? {1'b0, md_reg} : '0);
    assign div_rem = {hi_reg, sh_reg[WIDTH-1]};
    assign div_ge  = div_rem >= {1'b0, md_reg};
    assign ab_sum  = {1'b0, x_reg} + {1'b0, y_reg};

    // the new top entry of a row reads as zero
    assign cur_lo  = (j_reg == i_reg) ? '0 : rd_reg[WIDTH-1:0];
    assign cur_big = (j_reg == i_reg) ? 1'b0 : rd_reg[WIDTH];
    assign row_sum = {1'b0, cur_lo} + {1'b0, prev_reg};

    assign rd_addr = (uword.op == intu_pkg::OP_RD_K) ? k_reg : j_reg[CW-1:0];

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (busy_reg && uword.op == intu_pkg::OP_ROW_ADD)
        begin
            mem[j_reg[CW-1:0]] <= {cur_big || prev_big_reg || row_sum[WIDTH],
                                   row_sum[WIDTH-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (accept)
            begin
                a_reg   <= s_tdata[3 +: WIDTH];
                b_reg   <= s_tdata[3+WIDTH +: WIDTH];
                x_reg   <= s_tdata[3 +: WIDTH];
                y_reg   <= s_tdata[3+WIDTH +: WIDTH];
                n_reg   <= (32'(cnt_n_in) > COUNT_MAX) ? CW'(COUNT_MAX) : CW'(cnt_n_in);
                k_reg   <= (32'(cnt_k_in) > COUNT_MAX) ? CW'(COUNT_MAX) : CW'(cnt_k_in);
                bad_reg <= 1'b0;
                acc_reg <= '0;
                big_reg <= 1'b0;
            end
        end
        else
        begin
            unique case (uword.op)
                intu_pkg::OP_DIV_LD_AB:
                begin
                    sh_reg <= a_reg;
                    md_reg <= b_reg;
                    hi_reg <= '0;
                end
                intu_pkg::OP_DIV_LD_XG:
                begin
                    sh_reg <= x_reg;
                    md_reg <= a_reg;
                    hi_reg <= '0;
                end
                intu_pkg::OP_DIV:
                begin
                    hi_reg <= div_ge ? WIDTH'(div_rem - {1'b0, md_reg})
                                     : div_rem[WIDTH-1:0];
                    sh_reg <= {sh_reg[WIDTH-2:0], div_ge};
                end
                intu_pkg::OP_GCD_UPD:
                begin
                    a_reg <= b_reg;
                    b_reg <= hi_reg;
                end
                intu_pkg::OP_ACC_A:
                begin
                    acc_reg <= a_reg;
                    big_reg <= 1'b0;
                end
                intu_pkg::OP_ACC_Q:
                begin
                    acc_reg <= sh_reg;
                    big_reg <= 1'b0;
                end
                intu_pkg::OP_ACC0:
                begin
                    acc_reg <= '0;
                    big_reg <= 1'b0;
                end
                intu_pkg::OP_ACC1:
                begin
                    acc_reg <= WIDTH'(1);
                    big_reg <= 1'b0;
                end
                intu_pkg::OP_MUL_LD:
                begin
                    md_reg <= acc_reg;
                    sh_reg <= opnd;
                    hi_reg <= '0;
                    zf_reg <= (!big_reg && acc_reg == '0) || (!opnd_big && opnd == '0);
                    bf_reg <= big_reg || opnd_big;
                end
                intu_pkg::OP_MUL:
                begin
                    {hi_reg, sh_reg} <= {mul_sum, sh_reg[WIDTH-1:1]};
                end
                intu_pkg::OP_MUL_WB:
                begin
                    acc_reg <= sh_reg;
                    big_reg <= !zf_reg && (bf_reg || hi_reg != '0);
                end
                intu_pkg::OP_BASE_A:
                begin
                    base_reg     <= x_reg;
                    base_big_reg <= 1'b0;
                end
                intu_pkg::OP_BASE_SUM:
                begin
                    base_reg     <= ab_sum[WIDTH-1:0];
                    base_big_reg <= ab_sum[WIDTH];
                end
                intu_pkg::OP_I_ONE:
                begin
                    i_reg <= (CW+1)'(1);
                end
                intu_pkg::OP_I_NK:
                begin
                    i_reg <= {1'b0, n_reg} - {1'b0, k_reg} + 1'b1;
                end
                intu_pkg::OP_I_INC:
                begin
                    i_reg <= i_reg + 1'b1;
                end
                intu_pkg::OP_J_ONE:
                begin
                    j_reg        <= (CW+1)'(1);
                    prev_reg     <= WIDTH'(1);
                    prev_big_reg <= 1'b0;
                end
                intu_pkg::OP_ROW_ADD:
                begin
                    prev_reg     <= cur_lo;
                    prev_big_reg <= cur_big;
                    j_reg        <= j_reg + 1'b1;
                end
                intu_pkg::OP_ACC_MEM:
                begin
                    acc_reg <= (k_reg == '0) ? WIDTH'(1) : rd_reg[WIDTH-1:0];
                    big_reg <= (k_reg == '0) ? 1'b0 : rd_reg[WIDTH];
                end
                intu_pkg::OP_BAD:
                begin
                    bad_reg <= 1'b1;
                end
                intu_pkg::OP_DONE:
                begin
                    if (out_free)
                    begin
                        value_reg  <= bad_reg ? '0 : acc_reg;
                        ovf_reg    <= bad_reg ? 1'b0 : big_reg;
                        badout_reg <= bad_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
